/* sv/ctsc_pkg.sv */
package ctsc_pkg;

    // item kinds
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_UP    = 3'd1;
    localparam logic [2:0] KIND_DOWN  = 3'd2;
    localparam logic [2:0] KIND_NEXT  = 3'd3;
    localparam logic [2:0] KIND_PREV  = 3'd4;
    localparam logic [2:0] KIND_EXIT  = 3'd5;
    localparam logic [2:0] KIND_LOAD  = 3'd6;

    // field codes
    localparam logic [2:0] FLD_HOUR  = 3'd0;
    localparam logic [2:0] FLD_MIN   = 3'd1;
    localparam logic [2:0] FLD_SEC   = 3'd2;
    localparam logic [2:0] FLD_AMPM  = 3'd3;
    localparam logic [2:0] FLD_YEAR  = 3'd4;
    localparam logic [2:0] FLD_MONTH = 3'd5;
    localparam logic [2:0] FLD_DATE  = 3'd6;
    localparam logic [2:0] FLD_WDAY  = 3'd7;

    localparam int unsigned NUM_REGS = 7;
    localparam logic [2:0] HOUR_REG   = 3'd2;
    localparam logic [2:0] YEAR_REG   = 3'd6;
    localparam logic [2:0] MONTH_REG  = 3'd5;
    localparam logic [7:0] HOUR_MASK  = 8'h1F;
    localparam logic [7:0] MODE_MASK  = 8'h60;
    localparam int unsigned AMPM_BIT  = 5;
    localparam logic [4:0] LIMIT_RESET = 5'd31;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] reg_index;
        logic [7:0] reg_value;
    } t_in_item;

    typedef struct packed {
        logic       write_valid;
        logic [2:0] write_reg;
        logic [7:0] write_data;
        logic [2:0] field_now;
        logic [6:0] shown_value;
        logic       setting_active;
    } t_out_item;

    // clock register that holds each field
    function automatic logic [2:0] fld_reg(input logic [2:0] f);
        logic [2:0] r;
        unique case (f)
            FLD_HOUR:  r = 3'd2;
            FLD_MIN:   r = 3'd1;
            FLD_SEC:   r = 3'd0;
            FLD_AMPM:  r = 3'd2;
            FLD_YEAR:  r = 3'd6;
            FLD_MONTH: r = 3'd5;
            FLD_DATE:  r = 3'd4;
            default:   r = 3'd3;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] fld_lo(input logic [2:0] f);
        logic [6:0] r;
        unique case (f)
            FLD_HOUR, FLD_MONTH, FLD_DATE, FLD_WDAY: r = 7'd1;
            default:                                 r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] fld_hi(input logic [2:0] f);
        logic [6:0] r;
        unique case (f)
            FLD_HOUR:         r = 7'd12;
            FLD_MIN, FLD_SEC: r = 7'd59;
            FLD_AMPM:         r = 7'd1;
            FLD_YEAR:         r = 7'd99;
            FLD_MONTH:        r = 7'd12;
            FLD_DATE:         r = 7'd31;
            default:          r = 7'd7;
        endcase
        return r;
    endfunction

    // high nibble times ten plus low nibble
    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

    // divide by ten through multiply by 205 and shift by 11, exact for 7-bit values
    function automatic logic [7:0] bcd_enc(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  rem;
        prod = 15'(v) * 15'd205;
        q    = prod[14:11];
        rem  = v - 7'({q, 3'b000} + {2'b00, q, 1'b0});
        return {q, rem[3:0]};
    endfunction

endpackage

/* sv/ctsc_engine.sv */
module ctsc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  ctsc_pkg::t_in_item  i_item,
    output ctsc_pkg::t_out_item o_result
);

    logic [7:0] r_shadow [ctsc_pkg::NUM_REGS];
    logic [7:0] n_shadow [ctsc_pkg::NUM_REGS];
    logic [2:0] r_field, n_field;
    logic [6:0] r_work, n_work;
    logic [4:0] r_limit, n_limit;
    logic       r_active, n_active;

    logic       do_write;
    logic [2:0] wr_reg;
    logic [7:0] wr_data;
    logic       do_enter;
    logic [2:0] enter_fld;
    logic [7:0] enter_src;
    logic [7:0] dec_val;
    logic [7:0] year_dec;
    logic [7:0] month_dec;
    logic [6:0] lo_v, hi_v;
    logic [6:0] step_work;

    // write-back byte for the current field
    always_comb begin
        wr_reg = ctsc_pkg::fld_reg(r_field);
        unique case (r_field)
            ctsc_pkg::FLD_HOUR: begin
                wr_data = ctsc_pkg::bcd_enc(r_work)
                        | (r_shadow[ctsc_pkg::HOUR_REG] & ctsc_pkg::MODE_MASK);
            end
            ctsc_pkg::FLD_AMPM: begin
                wr_data = r_shadow[ctsc_pkg::HOUR_REG];
                wr_data[ctsc_pkg::AMPM_BIT] = r_work[0] | (|r_work[6:1]);
            end
            default: begin
                wr_data = ctsc_pkg::bcd_enc(r_work);
            end
        endcase
    end

    // item decode, adjust and shadow update
    always_comb begin
        n_shadow  = r_shadow;
        step_work = r_work;
        n_active  = r_active;
        do_write  = 1'b0;
        do_enter  = 1'b0;
        enter_fld = ctsc_pkg::FLD_HOUR;
        lo_v      = ctsc_pkg::fld_lo(r_field);
        hi_v      = ctsc_pkg::fld_hi(r_field);
        if (i_item.kind == ctsc_pkg::KIND_START) begin
            n_active = 1'b1;
            do_enter = 1'b1;
        end else if (i_item.kind == ctsc_pkg::KIND_LOAD) begin
            if (i_item.reg_index != 3'd7) begin
                n_shadow[i_item.reg_index] = i_item.reg_value;
            end
        end else if (i_item.kind == ctsc_pkg::KIND_UP
                     || i_item.kind == ctsc_pkg::KIND_DOWN) begin
            if (r_active) begin
                if (r_field == ctsc_pkg::FLD_AMPM) begin
                    step_work = r_work ^ 7'd1;
                end else if (r_field == ctsc_pkg::FLD_DATE) begin
                    if (i_item.kind == ctsc_pkg::KIND_UP) begin
                        step_work = (r_work >= {2'b00, r_limit}) ? {2'b00, r_limit}
                                                                 : r_work + 7'd1;
                    end else begin
                        step_work = (r_work <= 7'd1) ? 7'd1 : r_work - 7'd1;
                    end
                end else if (i_item.kind == ctsc_pkg::KIND_UP) begin
                    step_work = (r_work >= hi_v) ? lo_v : r_work + 7'd1;
                end else begin
                    step_work = (r_work <= lo_v) ? hi_v : r_work - 7'd1;
                end
            end
        end else if (i_item.kind == ctsc_pkg::KIND_NEXT
                     || i_item.kind == ctsc_pkg::KIND_PREV
                     || i_item.kind == ctsc_pkg::KIND_EXIT) begin
            if (r_active) begin
                do_write         = 1'b1;
                n_shadow[wr_reg] = wr_data;
                if (i_item.kind == ctsc_pkg::KIND_NEXT) begin
                    if (r_field == ctsc_pkg::FLD_WDAY) begin
                        n_active = 1'b0;
                    end else begin
                        do_enter  = 1'b1;
                        enter_fld = r_field + 3'd1;
                    end
                end else if (i_item.kind == ctsc_pkg::KIND_PREV) begin
                    do_enter  = 1'b1;
                    enter_fld = r_field - 3'd1;
                end else begin
                    n_active = 1'b0;
                end
            end
        end
    end

    // field entry reads the shadow after this item's write
    always_comb begin
        n_field   = r_field;
        n_limit   = r_limit;
        n_work    = step_work;
        enter_src = (enter_fld == ctsc_pkg::FLD_HOUR)
                  ? (n_shadow[ctsc_pkg::HOUR_REG] & ctsc_pkg::HOUR_MASK)
                  : n_shadow[ctsc_pkg::fld_reg(enter_fld)];
        dec_val   = ctsc_pkg::bcd_dec(enter_src);
        year_dec  = ctsc_pkg::bcd_dec(n_shadow[ctsc_pkg::YEAR_REG]);
        month_dec = ctsc_pkg::bcd_dec(n_shadow[ctsc_pkg::MONTH_REG]);
        if (do_enter) begin
            n_field = enter_fld;
            if (enter_fld == ctsc_pkg::FLD_AMPM) begin
                n_work = {6'b000000, n_shadow[ctsc_pkg::HOUR_REG][ctsc_pkg::AMPM_BIT]};
            end else if (dec_val < {1'b0, ctsc_pkg::fld_lo(enter_fld)}
                         || dec_val > {1'b0, ctsc_pkg::fld_hi(enter_fld)}) begin
                n_work = ctsc_pkg::fld_lo(enter_fld);
            end else begin
                n_work = dec_val[6:0];
            end
            // month length for the date field, leap when year divisible by four
            if (enter_fld == ctsc_pkg::FLD_DATE) begin
                if (month_dec == 8'd1 || month_dec == 8'd3 || month_dec == 8'd5
                    || month_dec == 8'd7 || month_dec == 8'd8 || month_dec == 8'd10
                    || month_dec == 8'd12) begin
                    n_limit = 5'd31;
                end else if (month_dec == 8'd2) begin
                    n_limit = (year_dec[1:0] == 2'b00) ? 5'd29 : 5'd28;
                end else begin
                    n_limit = 5'd30;
                end
            end
        end
    end

    // result of this item
    always_comb begin
        o_result.write_valid    = do_write;
        o_result.write_reg      = do_write ? wr_reg : 3'd0;
        o_result.write_data     = do_write ? wr_data : 8'd0;
        o_result.field_now      = n_field;
        o_result.shown_value    = n_work;
        o_result.setting_active = n_active;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ctsc_pkg::NUM_REGS; i++) begin
                r_shadow[i] <= 8'd0;
            end
            r_field  <= ctsc_pkg::FLD_HOUR;
            r_work   <= 7'd0;
            r_limit  <= ctsc_pkg::LIMIT_RESET;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_shadow <= n_shadow;
            r_field  <= n_field;
            r_work   <= n_work;
            r_limit  <= n_limit;
            r_active <= n_active;
        end
    end

endmodule

/* sv/clock_time_set_controller_core.sv */
// Time-setting controller of a real-time clock.
// Input channel (i_in_valid / i_in_item / o_in_stall) carries button events
// (start, up, down, next, previous, exit) and register loads that refresh the
// seven-byte BCD shadow of the clock registers.
// Output channel (o_out_valid / o_out_item / i_out_stall) returns exactly one
// item per input item: an optional register write-back plus the field being
// edited, its binary value and the setting-mode flag.
// An item passes through the input register and then the result register.
// Throughput is one item per cycle while the receiver does not stall; the state
// update is a single combinational pass between the two registers.
// When the receiver stalls, the result register holds its item; an empty input
// register still takes one more item, and o_in_stall rises once it holds one.
// Synchronous active-low reset empties both registers, clears the shadow,
// selects the hour field, clears the working value and setting mode, and sets
// the month length to 31.
module clock_time_set_controller_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ctsc_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ctsc_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    logic                r_in_valid;
    ctsc_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    ctsc_pkg::t_out_item r_out_item;
    ctsc_pkg::t_out_item result;
    logic                out_adv;
    logic                step;

    // handshake control
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;

    ctsc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* sim/tb_clock_time_set_controller_core.sv */
`timescale 1ns / 1ps

module tb_clock_time_set_controller_core;

    // clock register numbers not named in the package
    localparam logic [2:0] SEC_REG  = 3'd0;
    localparam logic [2:0] MIN_REG  = 3'd1;
    localparam logic [2:0] WDAY_REG = 3'd3;
    localparam logic [2:0] DATE_REG = 3'd4;
    localparam logic [2:0] NO_REG   = 3'd7;

    // kind code with no meaning
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic               drain;
        ctsc_pkg::t_in_item item;
    } t_queued_event;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    ctsc_pkg::t_in_item  in_item = '0;
    logic                in_stall;
    logic                out_valid;
    ctsc_pkg::t_out_item out_item;
    logic                out_stall = 1'b0;

    t_queued_event       event_q[$];
    ctsc_pkg::t_out_item result_q[$];
    int unsigned   n_sent = 0;
    int unsigned   n_got = 0;
    int unsigned   n_useful = 0;
    int unsigned   errors = 0;
    int unsigned   cyc = 0;

    // shadow of the clock registers and the editing state
    logic [7:0] shadow [0:6] = '{default: 8'h00};
    logic [2:0] sel_field = ctsc_pkg::FLD_HOUR;
    logic [6:0] work_val = 7'd0;
    int         month_days = 31;
    logic       setting_on = 1'b0;

    // no idling on either side in this window
    wire calm = (cyc >= 300) && (cyc < 600);

    clock_time_set_controller_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // field to clock register
    function automatic logic [2:0] home_reg(input logic [2:0] f);
        case (f)
            ctsc_pkg::FLD_HOUR, ctsc_pkg::FLD_AMPM: return ctsc_pkg::HOUR_REG;
            ctsc_pkg::FLD_MIN:                      return MIN_REG;
            ctsc_pkg::FLD_SEC:                      return SEC_REG;
            ctsc_pkg::FLD_YEAR:                     return ctsc_pkg::YEAR_REG;
            ctsc_pkg::FLD_MONTH:                    return ctsc_pkg::MONTH_REG;
            ctsc_pkg::FLD_DATE:                     return DATE_REG;
            default:                                return WDAY_REG;
        endcase
    endfunction

    function automatic int lowest(input logic [2:0] f);
        case (f)
            ctsc_pkg::FLD_HOUR, ctsc_pkg::FLD_MONTH,
            ctsc_pkg::FLD_DATE, ctsc_pkg::FLD_WDAY: return 1;
            default:                                return 0;
        endcase
    endfunction

    function automatic int highest(input logic [2:0] f);
        case (f)
            ctsc_pkg::FLD_HOUR, ctsc_pkg::FLD_MONTH: return 12;
            ctsc_pkg::FLD_MIN, ctsc_pkg::FLD_SEC:    return 59;
            ctsc_pkg::FLD_AMPM:                      return 1;
            ctsc_pkg::FLD_YEAR:                      return 99;
            ctsc_pkg::FLD_DATE:                      return 31;
            default:                                 return 7;
        endcase
    endfunction

    function automatic int bcd_value(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [7:0] to_bcd(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // load the working value of a field, out of range falls back to its lowest
    function automatic void enter_field(input logic [2:0] f);
        int v;
        int yr;
        int mo;
        sel_field = f;
        if (f == ctsc_pkg::FLD_AMPM) begin
            work_val = {6'd0, shadow[ctsc_pkg::HOUR_REG][ctsc_pkg::AMPM_BIT]};
        end else begin
            if (f == ctsc_pkg::FLD_HOUR)
                v = bcd_value(shadow[ctsc_pkg::HOUR_REG] & ctsc_pkg::HOUR_MASK);
            else
                v = bcd_value(shadow[home_reg(f)]);
            if (v < lowest(f) || v > highest(f))
                v = lowest(f);
            work_val = 7'(v);
            // date limit follows the stored year and month
            if (f == ctsc_pkg::FLD_DATE) begin
                yr = bcd_value(shadow[ctsc_pkg::YEAR_REG]);
                mo = bcd_value(shadow[ctsc_pkg::MONTH_REG]);
                case (mo)
                    1, 3, 5, 7, 8, 10, 12: month_days = 31;
                    2:                     month_days = (yr % 4 == 0) ? 29 : 28;
                    default:               month_days = 30;
                endcase
            end
        end
    endfunction

    function automatic void adjust(input logic up);
        int v;
        v = int'(work_val);
        if (sel_field == ctsc_pkg::FLD_AMPM) begin
            work_val = work_val ^ 7'd1;
        end else if (sel_field == ctsc_pkg::FLD_DATE) begin
            // date saturates at both ends
            if (up)
                v = (v >= month_days) ? month_days : v + 1;
            else
                v = (v <= 1) ? 1 : v - 1;
            work_val = 7'(v);
        end else begin
            if (up)
                v = (v >= highest(sel_field)) ? lowest(sel_field) : v + 1;
            else
                v = (v <= lowest(sel_field)) ? highest(sel_field) : v - 1;
            work_val = 7'(v);
        end
    endfunction

    // bcd write of the current field, hour keeps its mode bits
    function automatic logic [7:0] write_back();
        logic [7:0] d;
        if (sel_field == ctsc_pkg::FLD_HOUR) begin
            d = to_bcd(int'(work_val)) | (shadow[ctsc_pkg::HOUR_REG] & ctsc_pkg::MODE_MASK);
        end else if (sel_field == ctsc_pkg::FLD_AMPM) begin
            d = shadow[ctsc_pkg::HOUR_REG];
            d[ctsc_pkg::AMPM_BIT] = (work_val != 7'd0);
        end else begin
            d = to_bcd(int'(work_val));
        end
        shadow[home_reg(sel_field)] = d;
        return d;
    endfunction

    // advance the clock-setting state by one item and give its result
    function automatic ctsc_pkg::t_out_item apply_event(input ctsc_pkg::t_in_item it);
        ctsc_pkg::t_out_item o;
        logic [2:0]          f;
        o = '0;
        f = sel_field;
        case (it.kind)
            ctsc_pkg::KIND_START: begin
                setting_on = 1'b1;
                enter_field(ctsc_pkg::FLD_HOUR);
            end
            ctsc_pkg::KIND_LOAD: begin
                if (it.reg_index != NO_REG)
                    shadow[it.reg_index] = it.reg_value;
            end
            ctsc_pkg::KIND_UP, ctsc_pkg::KIND_DOWN: begin
                if (setting_on)
                    adjust(it.kind == ctsc_pkg::KIND_UP);
            end
            ctsc_pkg::KIND_NEXT, ctsc_pkg::KIND_PREV, ctsc_pkg::KIND_EXIT: begin
                if (setting_on) begin
                    o.write_valid = 1'b1;
                    o.write_reg   = home_reg(f);
                    o.write_data  = write_back();
                    if (it.kind == ctsc_pkg::KIND_NEXT) begin
                        if (f == ctsc_pkg::FLD_WDAY)
                            setting_on = 1'b0;
                        else
                            enter_field(f + 3'd1);
                    end else if (it.kind == ctsc_pkg::KIND_PREV) begin
                        enter_field(f - 3'd1);
                    end else begin
                        setting_on = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        o.field_now      = sel_field;
        o.shown_value    = work_val;
        o.setting_active = setting_on;
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cyc, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic add_event(input logic [2:0] kind, input logic [2:0] idx,
                             input logic [7:0] val, input logic drain, input bit counted);
        t_queued_event e;
        e.drain          = drain;
        e.item.kind      = kind;
        e.item.reg_index = idx;
        e.item.reg_value = val;
        event_q.push_back(e);
        if (counted)
            n_useful++;
    endtask

    task automatic add_button(input logic [2:0] kind, input logic drain);
        add_event(kind, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), drain, 1'b1);
    endtask

    // register byte: mostly small or valid bcd, sometimes anything
    task automatic add_load();
        logic [2:0] idx;
        logic [7:0] val;
        int         p;
        idx = 3'($urandom_range(0, 7));
        p = $urandom_range(0, 9);
        if (p < 5) begin
            val = to_bcd($urandom_range(0, 12));
            if (idx == ctsc_pkg::HOUR_REG)
                val = val | {1'b0, 2'($urandom_range(0, 3)), 5'd0};
        end else if (p < 8) begin
            val = to_bcd($urandom_range(0, 99));
        end else begin
            val = 8'($urandom_range(0, 255));
        end
        add_event(ctsc_pkg::KIND_LOAD, idx, val, 1'b0, 1'b1);
    endtask

    // one setting session: start, edits over one or more fields, sometimes leave
    task automatic add_session(input logic drain);
        int nf;
        int nb;
        int p;
        repeat ($urandom_range(0, 2)) add_load();
        add_button(ctsc_pkg::KIND_START, drain);
        nf = $urandom_range(1, 10);
        repeat (nf) begin
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            repeat (nb)
                add_button($urandom_range(0, 1) ? ctsc_pkg::KIND_UP : ctsc_pkg::KIND_DOWN,
                           1'b0);
            if ($urandom_range(0, 14) == 0)
                add_load();
            p = $urandom_range(0, 19);
            if (p < 14)
                add_button(ctsc_pkg::KIND_NEXT, 1'b0);
            else if (p < 18)
                add_button(ctsc_pkg::KIND_PREV, 1'b0);
            else if (p < 19)
                add_button(ctsc_pkg::KIND_EXIT, 1'b0);
            else
                add_button(ctsc_pkg::KIND_START, 1'b0);
        end
        if ($urandom_range(0, 1))
            add_button(ctsc_pkg::KIND_EXIT, 1'b0);
    endtask

    // sender: items from the queue, random gaps, drain before marked items
    always @(posedge clk) begin
        t_queued_event nxt;
        logic          fire;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                result_q.push_back(apply_event(in_item));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || !in_stall) begin
                fire = (event_q.size() > 0) && (calm || $urandom_range(0, 99) >= 21);
                if (fire && event_q[0].drain)
                    fire = !in_valid && (n_sent == n_got);
                if (fire) begin
                    nxt = event_q.pop_front();
                    in_item  <= nxt.item;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, compare each result with the oldest one due
    always @(posedge clk) begin
        ctsc_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_got <= n_got + 1;
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing due");
                end else begin
                    want = result_q.pop_front();
                    check_field("write_valid", out_item.write_valid, want.write_valid);
                    check_field("write_reg", out_item.write_reg, want.write_reg);
                    check_field("write_data", out_item.write_data, want.write_data);
                    check_field("field_now", out_item.field_now, want.field_now);
                    check_field("shown_value", out_item.shown_value, want.shown_value);
                    check_field("setting_active", out_item.setting_active,
                                want.setting_active);
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 21);
        end
    end

    // cycle count and timeout
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        // button presses while idle, unknown kind, load to the missing register
        add_button(ctsc_pkg::KIND_UP, 1'b0);
        add_button(KIND_UNUSED, 1'b0);
        add_event(ctsc_pkg::KIND_LOAD, NO_REG, 8'hFF, 1'b0, 1'b1);
        // 12 o'clock with both mode bits, 59 min, leap year February 31st
        add_event(ctsc_pkg::KIND_LOAD, ctsc_pkg::HOUR_REG, 8'h72, 1'b0, 1'b1);
        add_event(ctsc_pkg::KIND_LOAD, MIN_REG, 8'h59, 1'b0, 1'b1);
        add_event(ctsc_pkg::KIND_LOAD, SEC_REG, 8'h00, 1'b0, 1'b1);
        add_event(ctsc_pkg::KIND_LOAD, ctsc_pkg::YEAR_REG, 8'h24, 1'b0, 1'b1);
        add_event(ctsc_pkg::KIND_LOAD, ctsc_pkg::MONTH_REG, 8'h02, 1'b0, 1'b1);
        add_event(ctsc_pkg::KIND_LOAD, DATE_REG, 8'h31, 1'b0, 1'b1);
        add_event(ctsc_pkg::KIND_LOAD, WDAY_REG, 8'h07, 1'b0, 1'b1);
        // hour wraps both ways, minute wraps up
        add_button(ctsc_pkg::KIND_START, 1'b0);
        add_button(ctsc_pkg::KIND_UP, 1'b0);
        add_button(ctsc_pkg::KIND_DOWN, 1'b0);
        add_button(ctsc_pkg::KIND_NEXT, 1'b0);
        add_button(ctsc_pkg::KIND_UP, 1'b0);
        // previous at hour goes to weekday, weekday wraps, date clips to the month
        add_button(ctsc_pkg::KIND_PREV, 1'b0);
        add_button(ctsc_pkg::KIND_PREV, 1'b0);
        add_button(ctsc_pkg::KIND_UP, 1'b0);
        add_button(ctsc_pkg::KIND_PREV, 1'b0);
        add_button(ctsc_pkg::KIND_UP, 1'b0);
        // load while active, then bad bcd falls back to the lowest value
        add_event(ctsc_pkg::KIND_LOAD, MIN_REG, 8'hFF, 1'b0, 1'b1);
        add_button(ctsc_pkg::KIND_EXIT, 1'b0);
        add_button(ctsc_pkg::KIND_START, 1'b0);
        add_button(ctsc_pkg::KIND_NEXT, 1'b0);
        add_button(ctsc_pkg::KIND_START, 1'b0);
        add_button(ctsc_pkg::KIND_EXIT, 1'b0);

        // random sessions with some noise in between
        n_useful = 0;
        add_session(1'b1);
        while (n_useful < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4))
                    add_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            add_session($urandom_range(0, 11) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (event_q.size() > 0 || in_valid || n_got < n_sent)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (result_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", result_q.size()));

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
sv/ctsc_pkg.sv
sv/ctsc_engine.sv
sv/clock_time_set_controller_core.sv
sim/tb_clock_time_set_controller_core.sv
